[rtl/core/dlr_pkg.sv]
// dlr_pkg: shared constants, codes and types of the dense layer with ReLU.
// No dependencies; imported by the top level, the MAC unit and the checker.
package dlr_pkg;

  // Default store geometry
  localparam int MAX_INPUTS_DEF  = 16;
  localparam int MAX_NEURONS_DEF = 16;

  // Field and datapath widths
  localparam int IDX_W = 4;
  localparam int ACT_W = 16;
  localparam int WGT_W = 11;
  localparam int PRD_W = ACT_W + WGT_W;
  // At most 31 products of magnitude 2^25 or less: always fits 32 bits signed.
  localparam int ACC_W = 32;
  localparam int RES_W = 31;
  localparam int CNT_W = 5;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Register indexes (paddr[2])
  localparam logic REG_NUM_INPUTS  = 1'b0;
  localparam logic REG_NUM_NEURONS = 1'b1;

  // Input word opcodes
  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_ACT    = 1'b1;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } dlr_mac_ctl_t;

endpackage

[rtl/core/dlr_mac.sv]
// dlr_mac: shared multiply-accumulate unit, one product per cycle.
// Depends on dlr_pkg.
module dlr_mac
  import dlr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dlr_mac_ctl_t            ctl_i,
  input  logic signed [ACT_W-1:0] act_i,
  input  logic signed [WGT_W-1:0] wgt_i,
  output logic signed [ACC_W-1:0] sum_o,
  output logic                    done_o
);

  logic signed [PRD_W-1:0] prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                    pv_q;
  logic                    pfirst_q;
  logic                    plast_q;
  logic                    done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q     <= 1'b0;
      pfirst_q <= 1'b0;
      plast_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      pv_q     <= ctl_i.valid;
      pfirst_q <= ctl_i.first;
      plast_q  <= ctl_i.last;
      done_q   <= pv_q && plast_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      prod_q <= act_i * wgt_i;
    end
    if (pv_q) begin
      acc_q <= (pfirst_q ? ACC_W'(0) : acc_q) + ACC_W'(prod_q);
    end
  end

  assign sum_o  = acc_q;
  assign done_o = done_q;

endmodule

[rtl/core/dense_layer_relu.sv]
// dense_layer_relu: fully connected integer layer with ReLU and saturation.
// Depends on dlr_pkg and dlr_mac.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  in      | input     | in_valid_i / in_stall_o | opcode, neuron_index, input_index,
//          |           |                        | value, last_input
//  out     | output    | out_valid_o/out_stall_i | out_neuron, activation_out, last_out
//  cfg     | input     | psel/penable/pready    | paddr, pwdata, prdata
//
// Weight words and activation words without last_input are stored without stalling
// the input. A last activation word starts the compute: each neuron passes, on the
// single multiply-accumulate unit, through issue, memory read, product, accumulate
// and emit, and the output stall can hold the result in emit.
// in_stall_o stays high for the whole compute. Reset clears the sequencer and sets
// both count registers to 16; the stores hold nothing defined until written.
module dense_layer_relu
  import dlr_pkg::*;
#(
  parameter int MAX_INPUTS  = MAX_INPUTS_DEF,
  parameter int MAX_NEURONS = MAX_NEURONS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // input words
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    opcode_i,
  input  logic [IDX_W-1:0]        neuron_index_i,
  input  logic [IDX_W-1:0]        input_index_i,
  input  logic signed [ACT_W-1:0] value_i,
  input  logic                    last_input_i,
  // result words
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [IDX_W-1:0]        out_neuron_o,
  output logic [RES_W-1:0]        activation_out_o,
  output logic                    last_out_o,
  // configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_AW-1:0]       paddr,
  input  logic [CFG_DW-1:0]       pwdata,
  output logic [CFG_DW-1:0]       prdata,
  output logic                    pready
);

  localparam int WDEPTH = MAX_INPUTS * MAX_NEURONS;
  localparam int AIW    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  // ---------------------------------------------------------------- config
  logic [CNT_W-1:0] num_inputs_q;
  logic [CNT_W-1:0] num_neurons_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_inputs_q  <= CNT_W'(16);
      num_neurons_q <= CNT_W'(16);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_NUM_INPUTS:  num_inputs_q  <= pwdata[CNT_W-1:0];
        REG_NUM_NEURONS: num_neurons_q <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_NUM_INPUTS:  prdata = CFG_DW'(num_inputs_q);
      REG_NUM_NEURONS: prdata = CFG_DW'(num_neurons_q);
      default:         prdata = '0;
    endcase
  end

  // zero counts as one, above the store size counts as the store size
  logic [CNT_W-1:0] eff_ni;
  logic [CNT_W-1:0] eff_nn;

  always_comb begin
    if (num_inputs_q == '0) begin
      eff_ni = CNT_W'(1);
    end else if (int'(num_inputs_q) > MAX_INPUTS) begin
      eff_ni = CNT_W'(MAX_INPUTS);
    end else begin
      eff_ni = num_inputs_q;
    end
    if (num_neurons_q == '0) begin
      eff_nn = CNT_W'(1);
    end else if (int'(num_neurons_q) > MAX_NEURONS) begin
      eff_nn = CNT_W'(MAX_NEURONS);
    end else begin
      eff_nn = num_neurons_q;
    end
  end

  logic [CNT_W-1:0] ni_last;
  logic [CNT_W-1:0] nn_last;
  assign ni_last = eff_ni - CNT_W'(1);
  assign nn_last = eff_nn - CNT_W'(1);

  // ---------------------------------------------------------------- input
  logic [1:0] state_q;
  logic [1:0] state_d;
  logic       in_acc;
  logic       start;
  logic       w_wr;
  logic       a_wr;
  logic [WAW-1:0] w_waddr;
  logic [AIW-1:0] a_waddr;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign start      = in_acc && (opcode_i == OP_ACT) && last_input_i;

  assign w_wr = in_acc && (opcode_i == OP_WEIGHT) &&
                (32'(neuron_index_i) < MAX_NEURONS) &&
                (32'(input_index_i) < MAX_INPUTS);
  assign a_wr = in_acc && (opcode_i == OP_ACT) &&
                (32'(input_index_i) < MAX_INPUTS);

  assign w_waddr = WAW'(32'(neuron_index_i) * MAX_INPUTS + 32'(input_index_i));
  assign a_waddr = AIW'(input_index_i);

  // ---------------------------------------------------------------- stores
  logic signed [WGT_W-1:0] wmem [WDEPTH];
  logic signed [ACT_W-1:0] amem [MAX_INPUTS];
  logic signed [WGT_W-1:0] w_rd_q;
  logic signed [ACT_W-1:0] a_rd_q;
  logic [CNT_W-1:0]        i_q;
  logic [CNT_W-1:0]        n_q;
  logic [WAW-1:0]          wbase_q;
  logic [WAW-1:0]          wptr_q;
  logic                    issue;

  assign issue = (state_q == S_ISSUE);

  always_ff @(posedge clk_i) begin
    if (w_wr) begin
      wmem[w_waddr] <= value_i[WGT_W-1:0];
    end
    if (issue) begin
      w_rd_q <= wmem[wptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_wr) begin
      amem[a_waddr] <= value_i;
    end
    if (issue) begin
      a_rd_q <= amem[AIW'(i_q)];
    end
  end

  // ---------------------------------------------------------------- sequencer
  logic                    s1_v_q;
  logic                    s1_first_q;
  logic                    s1_last_q;
  logic                    out_valid_q;
  logic                    emit_load;
  logic                    last_neuron;
  logic                    mac_done;
  logic signed [ACC_W-1:0] mac_sum;
  dlr_mac_ctl_t            mac_ctl;

  assign last_neuron = (n_q == nn_last);
  assign emit_load   = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start) state_d = S_ISSUE;
      S_ISSUE: if (i_q == ni_last) state_d = S_DRAIN;
      S_DRAIN: if (mac_done) state_d = S_EMIT;
      S_EMIT:  if (emit_load) state_d = last_neuron ? S_IDLE : S_ISSUE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      n_q         <= '0;
      wbase_q     <= '0;
      wptr_q      <= '0;
      s1_v_q      <= 1'b0;
      s1_first_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      s1_v_q     <= issue;
      s1_first_q <= (i_q == '0);
      s1_last_q  <= (i_q == ni_last);
      case (state_q)
        S_IDLE: begin
          if (start) begin
            i_q     <= '0;
            n_q     <= '0;
            wbase_q <= '0;
            wptr_q  <= '0;
          end
        end
        S_ISSUE: begin
          i_q    <= (i_q == ni_last) ? '0 : i_q + CNT_W'(1);
          wptr_q <= wptr_q + WAW'(1);
        end
        S_EMIT: begin
          if (emit_load) begin
            n_q     <= n_q + CNT_W'(1);
            wbase_q <= WAW'(32'(wbase_q) + MAX_INPUTS);
            wptr_q  <= WAW'(32'(wbase_q) + MAX_INPUTS);
          end
        end
        default: ;
      endcase
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign mac_ctl.valid = s1_v_q;
  assign mac_ctl.first = s1_first_q;
  assign mac_ctl.last  = s1_last_q;

  dlr_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .act_i  (a_rd_q),
    .wgt_i  (w_rd_q),
    .sum_o  (mac_sum),
    .done_o (mac_done)
  );

  // ---------------------------------------------------------------- result
  logic [IDX_W-1:0] out_neuron_q;
  logic [RES_W-1:0] act_out_q;
  logic             last_out_q;

  // a sum never exceeds the positive range of the accumulator, so ReLU is
  // all the clamping left to do
  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_neuron_q <= n_q[IDX_W-1:0];
      act_out_q    <= mac_sum[ACC_W-1] ? '0 : mac_sum[RES_W-1:0];
      last_out_q   <= last_neuron;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_neuron_o     = out_neuron_q;
  assign activation_out_o = act_out_q;
  assign last_out_o       = last_out_q;

endmodule

[rtl/core/dlr_checker.sv]
// dlr_checker: port-level assertions for dense_layer_relu, bound to the top.
// Depends on dlr_pkg.
module dlr_checker
  import dlr_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    opcode_i,
  input logic                    last_input_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [IDX_W-1:0]        out_neuron_o,
  input logic [RES_W-1:0]        activation_out_o,
  input logic                    last_out_o,
  input logic                    pready
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_neuron_o) &&
    $stable(activation_out_o) && $stable(last_out_o))
    else $error("stalled result word changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  // a last activation word starts the compute, which stalls the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (opcode_i == OP_ACT) && last_input_i
    |=> in_stall_o)
    else $error("compute did not start");

  // any other word is absorbed and the input is not stalled in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !((opcode_i == OP_ACT) && last_input_i)
    |=> !in_stall_o)
    else $error("input stalled after a store word");

endmodule

bind dense_layer_relu dlr_checker u_dlr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .opcode_i         (opcode_i),
  .last_input_i     (last_input_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .out_neuron_o     (out_neuron_o),
  .activation_out_o (activation_out_o),
  .last_out_o       (last_out_o),
  .pready           (pready)
);

[test/tb_top.sv]
// tb_top: self-checking bench for dense_layer_relu (fully connected layer, ReLU).
// Depends on dlr_pkg and the RTL; a scoreboard class predicts every result word
// from the accepted input words and the register settings.
`timescale 1ns / 1ps

module tb_top;
  import dlr_pkg::*;

  localparam int CLK_HALF   = 4;
  localparam int CYCLE_CAP  = 1000000;
  localparam int SETTLE_CYC = 24;
  localparam int HOLD_CYC   = 400;
  localparam int PHASE_WORDS = 10;
  localparam int STORE_DEPTH = MAX_NEURONS_DEF * MAX_INPUTS_DEF;

  typedef struct packed {
    logic [IDX_W-1:0] neuron;
    logic [RES_W-1:0] act;
    logic             last;
  } layer_result_t;

  class layer_scoreboard;
    logic signed [WGT_W-1:0] weights [STORE_DEPTH];
    logic signed [ACT_W-1:0] acts [MAX_INPUTS_DEF];
    logic [CNT_W-1:0]        num_inputs_q;
    logic [CNT_W-1:0]        num_neurons_q;
    layer_result_t           expected_results[$];
    int                      errors;

    function new();
      foreach (weights[k]) weights[k] = '0;
      foreach (acts[k]) acts[k] = '0;
      num_inputs_q  = CNT_W'(16);
      num_neurons_q = CNT_W'(16);
      errors = 0;
    endfunction

    function int clamp_count(logic [CNT_W-1:0] v, int maxv);
      if (v == '0) return 1;
      if (int'(v) > maxv) return maxv;
      return int'(v);
    endfunction

    function int active_inputs();
      return clamp_count(num_inputs_q, MAX_INPUTS_DEF);
    endfunction

    function int active_neurons();
      return clamp_count(num_neurons_q, MAX_NEURONS_DEF);
    endfunction

    function void set_reg(logic idx, logic [CFG_DW-1:0] data);
      if (idx == REG_NUM_INPUTS) num_inputs_q = data[CNT_W-1:0];
      else num_neurons_q = data[CNT_W-1:0];
    endfunction

    function void predict_layer();
      int ni;
      int nn;
      longint sum;
      layer_result_t r;
      ni = active_inputs();
      nn = active_neurons();
      for (int n = 0; n < nn; n++) begin
        sum = 0;
        for (int i = 0; i < ni; i++)
          sum += longint'(acts[i]) * longint'(weights[n * MAX_INPUTS_DEF + i]);
        r.neuron = IDX_W'(n);
        if (sum < 0) r.act = '0;
        else if (sum > 64'sd2147483647) r.act = {RES_W{1'b1}};
        else r.act = sum[RES_W-1:0];
        r.last = (n + 1 == nn);
        expected_results.insert(expected_results.size(), r);
      end
    endfunction

    function void note_word(logic op, logic [IDX_W-1:0] n, logic [IDX_W-1:0] i,
                            logic [ACT_W-1:0] v, logic last);
      if (op == OP_WEIGHT) begin
        weights[int'(n) * MAX_INPUTS_DEF + int'(i)] = v[WGT_W-1:0];
      end else begin
        acts[i] = v;
        if (last) predict_layer();
      end
    endfunction

    function void check_result(logic [IDX_W-1:0] n, logic [RES_W-1:0] a, logic l);
      layer_result_t e;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result word: neuron %0d act %0d last %0b", n, a, l);
        return;
      end
      e = expected_results.pop_front();
      if (e.neuron !== n || e.act !== a || e.last !== l) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected neuron %0d act %0d last %0b, got neuron %0d act %0d last %0b",
                   e.neuron, e.act, e.last, n, a, l);
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic                    opcode_i = OP_WEIGHT;
  logic [IDX_W-1:0]        neuron_index_i = '0;
  logic [IDX_W-1:0]        input_index_i = '0;
  logic signed [ACT_W-1:0] value_i = '0;
  logic                    last_input_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [IDX_W-1:0]        out_neuron_o;
  logic [RES_W-1:0]        activation_out_o;
  logic                    last_out_o;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [CFG_AW-1:0]       paddr = '0;
  logic [CFG_DW-1:0]       pwdata = '0;
  logic [CFG_DW-1:0]       prdata;
  logic                    pready;

  layer_scoreboard sb;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_active = 1'b0;
  int  sent_cnt = 0;
  int  cycle_cnt;
  bit  w_written [STORE_DEPTH];
  bit  a_written [MAX_INPUTS_DEF];

  dense_layer_relu dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .neuron_index_i   (neuron_index_i),
    .input_index_i    (input_index_i),
    .value_i          (value_i),
    .last_input_i     (last_input_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_neuron_o     (out_neuron_o),
    .activation_out_o (activation_out_o),
    .last_out_o       (last_out_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  initial begin
    for (cycle_cnt = 0; cycle_cnt < CYCLE_CAP; cycle_cnt++) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: check accepted words, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i)
      sb.check_result(out_neuron_o, activation_out_o, last_out_o);
    out_stall_i <= hold_active || ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [ACT_W-1:0] rand_weight();
    if ($urandom_range(99) < 75) return ACT_W'($urandom_range(0, 1998)) - ACT_W'(999);
    return ACT_W'($urandom);
  endfunction

  function automatic logic [ACT_W-1:0] rand_act();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 16'h7fff;
    if (r < 20) return 16'h8000;
    if (r < 45) return ACT_W'($urandom_range(0, 200)) - ACT_W'(100);
    return ACT_W'($urandom);
  endfunction

  // one input word: optional idle gap, then hold until accepted
  task automatic push_word(logic op, logic [IDX_W-1:0] n, logic [IDX_W-1:0] i,
                           logic [ACT_W-1:0] v, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    neuron_index_i <= n;
    input_index_i  <= i;
    value_i        <= v;
    last_input_i   <= last;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_word(op, n, i, v, last);
    if (op == OP_WEIGHT) w_written[int'(n) * MAX_INPUTS_DEF + int'(i)] = 1'b1;
    else a_written[i] = 1'b1;
    sent_cnt++;
  endtask

  // write whatever the active layer would read but was never stored
  task automatic fill_missing();
    int ni;
    int nn;
    ni = sb.active_inputs();
    nn = sb.active_neurons();
    for (int n = 0; n < nn; n++)
      for (int i = 0; i < ni; i++)
        if (!w_written[n * MAX_INPUTS_DEF + i])
          push_word(OP_WEIGHT, IDX_W'(n), IDX_W'(i), rand_weight(), 1'b0);
    for (int i = 0; i < ni; i++)
      if (!a_written[i]) push_word(OP_ACT, IDX_W'($urandom), IDX_W'(i), rand_act(), 1'b0);
  endtask

  task automatic put_word(logic op, logic [IDX_W-1:0] n, logic [IDX_W-1:0] i,
                          logic [ACT_W-1:0] v, logic last);
    if (op == OP_ACT && last) fill_missing();
    push_word(op, n, i, v, last);
  endtask

  // weight updates, then a full activation vector; some are cut short
  task automatic run_layer();
    int ni;
    int nn;
    bit broken;
    logic [IDX_W-1:0] tail_idx;
    ni = sb.active_inputs();
    nn = sb.active_neurons();
    broken = ($urandom_range(99) < 12);
    repeat ($urandom_range(0, 5)) begin
      if ($urandom_range(99) < 90)
        put_word(OP_WEIGHT, IDX_W'($urandom_range(0, nn - 1)), IDX_W'($urandom_range(0, ni - 1)),
                 rand_weight(), 1'($urandom));
      else
        put_word(OP_WEIGHT, IDX_W'($urandom), IDX_W'($urandom), rand_weight(), 1'($urandom));
    end
    for (int i = 0; i < ni - 1; i++)
      put_word(OP_ACT, IDX_W'($urandom), IDX_W'(i), rand_act(), 1'b0);
    tail_idx = ($urandom_range(99) < 85) ? IDX_W'(ni - 1) : IDX_W'($urandom);
    put_word(OP_ACT, IDX_W'($urandom), tail_idx, rand_act(), !broken);
  endtask

  task automatic run_random(int words);
    int target;
    target = sent_cnt + words;
    while (sent_cnt < target) begin
      if ($urandom_range(99) < 10)
        put_word(1'($urandom), IDX_W'($urandom), IDX_W'($urandom), ACT_W'($urandom), 1'($urandom));
      else
        run_layer();
    end
  endtask

  // drop valid, wait for the last result word, then let the datapath drain
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic idx, logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic hold_off();
    hold_active <= 1'b1;
    repeat (HOLD_CYC) @(posedge clk_i);
    hold_active <= 1'b0;
  endtask

  task automatic run_directed();
    // weight words keep only 11 bits; last_input is a don't-care on them
    put_word(OP_WEIGHT, 4'd0, 4'd0, 16'h7fff, 1'b1);
    put_word(OP_WEIGHT, 4'd0, 4'd1, 16'h8000, 1'b0);
    put_word(OP_WEIGHT, 4'd0, 4'd2, 16'd999, 1'b0);
    put_word(OP_WEIGHT, 4'd1, 4'd0, -16'sd999, 1'b0);
    put_word(OP_WEIGHT, 4'd1, 4'd1, 16'd1023, 1'b0);
    put_word(OP_WEIGHT, 4'd1, 4'd2, -16'sd1024, 1'b0);
    put_word(OP_WEIGHT, 4'd15, 4'd15, 16'h5555, 1'b0);
    // neuron_index ignored on activations; index 15 lies beyond the layer
    put_word(OP_ACT, 4'd15, 4'd0, 16'h7fff, 1'b0);
    put_word(OP_ACT, 4'd0, 4'd1, 16'h8000, 1'b0);
    put_word(OP_ACT, 4'd0, 4'd15, 16'hffff, 1'b0);
    put_word(OP_ACT, 4'd0, 4'd2, 16'd1000, 1'b0);
    put_word(OP_ACT, 4'd0, 4'd2, 16'd1000, 1'b1);
    // negative sums clamp to zero
    put_word(OP_ACT, 4'd0, 4'd2, 16'h8000, 1'b1);
    // last on an index outside the active inputs still starts the layer
    put_word(OP_WEIGHT, 4'd1, 4'd0, -16'sd1024, 1'b0);
    put_word(OP_ACT, 4'd10, 4'd15, 16'd0, 1'b1);
    put_word(OP_ACT, 4'd0, 4'd0, 16'd0, 1'b0);
    put_word(OP_ACT, 4'd0, 4'd1, 16'd0, 1'b0);
    put_word(OP_ACT, 4'd0, 4'd2, 16'd0, 1'b1);
  endtask

  initial begin
    sb = new();
    foreach (w_written[k]) w_written[k] = 1'b0;
    foreach (a_written[k]) a_written[k] = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    cfg_write(REG_NUM_INPUTS, 32'd3);
    cfg_write(REG_NUM_NEURONS, 32'd2);
    run_directed();
    settle();

    // smallest layer, no idling
    cfg_write(REG_NUM_INPUTS, 32'd1);
    cfg_write(REG_NUM_NEURONS, 32'd1);
    run_random(PHASE_WORDS);
    settle();

    // zero neurons counts as one; sender mostly idle
    cfg_write(REG_NUM_INPUTS, 32'd7);
    cfg_write(REG_NUM_NEURONS, 32'd0);
    send_idle_pct = 81;
    run_random(PHASE_WORDS);
    settle();

    // full layer; receiver mostly stalled
    cfg_write(REG_NUM_INPUTS, 32'd16);
    cfg_write(REG_NUM_NEURONS, 32'd16);
    send_idle_pct = 0;
    recv_stall_pct = 81;
    run_random(PHASE_WORDS);
    settle();

    // counts above the maximum saturate; light idling on both sides
    cfg_write(REG_NUM_INPUTS, 32'd31);
    cfg_write(REG_NUM_NEURONS, 32'd17);
    send_idle_pct = 7;
    recv_stall_pct = 7;
    run_random(PHASE_WORDS);
    settle();

    // long receiver hold-off while words keep coming
    cfg_write(REG_NUM_INPUTS, 32'd0);
    cfg_write(REG_NUM_NEURONS, 32'd12);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      hold_off();
      run_random(PHASE_WORDS);
    join
    settle();

    // random register words, upper bits included
    cfg_write(REG_NUM_INPUTS, $urandom);
    cfg_write(REG_NUM_NEURONS, $urandom);
    send_idle_pct = 7 * $urandom_range(0, 1);
    recv_stall_pct = 81 * $urandom_range(0, 1);
    run_random(PHASE_WORDS);
    settle();

    repeat (64) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
